@@ rtl/fixed_point_sine_cosine_defines.svh @@
// Assertion macros shared by the sine/cosine checker.
`ifndef FIXED_POINT_SINE_COSINE_DEFINES_SVH
`define FIXED_POINT_SINE_COSINE_DEFINES_SVH

// Condition implies consequence in the same cycle, ignored during reset
`define FPSC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fpsc same-cycle check failed");

// Condition implies consequence in the next cycle, ignored during reset
`define FPSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fpsc next-cycle check failed");

// Condition implies consequence in the next cycle, checked through reset
`define FPSC_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("fpsc reset check failed");

`endif

@@ rtl/fpsc_pkg.sv @@
// Shared constants and the quarter-wave table for the sine/cosine block.
`timescale 1ns / 1ps
`default_nettype none

package fpsc_pkg;

   localparam int ANGLE_W = 16;
   localparam int OUT_W   = 16;
   localparam int TBL_W   = 15;
   localparam int TBL_N   = 65;

   // A full turn spans 0..FULL_TURN counts; a quarter turn is added for cosine
   localparam logic [16:0] FULL_TURN    = 17'd65535;
   localparam logic [16:0] QUARTER_TURN = 17'd16384;

   // First quadrant of sine, Q15, 64 segments plus the end point
   localparam logic [TBL_W-1:0] QWAVE [0:TBL_N-1] = '{
      15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
      15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
      15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
      15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
      15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
      15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
      15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
      15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
      15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
      15'd32757, 15'd32767
   };

endpackage

`default_nettype wire

@@ rtl/fpsc_eval.sv @@
// Sine of one angle: step rescale, quadrant mirroring, linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

module fpsc_eval (
   input  wire logic        [fpsc_pkg::ANGLE_W-1:0] angle,
   output logic signed      [fpsc_pkg::OUT_W-1:0]   sine
);

   logic        [15:0] steps;
   logic        [7:0]  idx;
   logic        [7:0]  frac;
   logic        [5:0]  seg;
   logic               neg;
   logic        [6:0]  q1;
   logic        [6:0]  q2;
   logic        [fpsc_pkg::TBL_W-1:0] mag1;
   logic        [fpsc_pkg::TBL_W-1:0] mag2;
   logic signed [16:0] t1;
   logic signed [16:0] t2;
   logic signed [16:0] diff;
   logic signed [25:0] prod;
   logic signed [25:0] prod_adj;
   logic signed [17:0] interp;
   logic signed [17:0] total;

   // angle * 65536 / 65535 equals angle, except a full turn wraps to step 0
   assign steps = (angle == fpsc_pkg::FULL_TURN[15:0]) ? 16'd0 : angle;
   assign idx   = steps[15:8];
   assign frac  = steps[7:0];
   assign seg   = idx[5:0];
   assign neg   = idx[7];

   // odd quadrants run the table backwards
   assign q1 = idx[6] ? 7'(7'd64 - {1'b0, seg}) : {1'b0, seg};
   assign q2 = idx[6] ? 7'(7'd63 - {1'b0, seg}) : 7'({1'b0, seg} + 7'd1);

   assign mag1 = fpsc_pkg::QWAVE[q1];
   assign mag2 = fpsc_pkg::QWAVE[q2];

   // lower half of the turn is negated
   assign t1 = neg ? -$signed({2'b00, mag1}) : $signed({2'b00, mag1});
   assign t2 = neg ? -$signed({2'b00, mag2}) : $signed({2'b00, mag2});

   // (t2 - t1) * frac / 256, rounded toward zero
   assign diff     = t2 - t1;
   assign prod     = 26'(diff) * 26'($signed({1'b0, frac}));
   assign prod_adj = prod + (prod[25] ? 26'sd255 : 26'sd0);
   assign interp   = 18'(prod_adj >>> 8);

   assign total = 18'(t1) + interp;
   assign sine  = $signed(total[15:0]);

endmodule

`default_nettype wire

@@ rtl/fixed_point_sine_cosine.sv @@
// Top level: input register, sine and cosine evaluation, result register.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-point sine and cosine. A 16-bit angle (full turn = 0..65535) gives
// Q15 sine and cosine through a 65-entry quarter-wave table with linear
// interpolation. Two register stages: the request is captured in the input
// register, each value is evaluated by table lookup and one multiply, and
// captured in the result register. rsp_valid rises when the request moves
// from the input register into the result register; one request is taken
// every cycle while rsp_stall is low. The result register frees the input
// side whenever it is empty or being taken.

module fixed_point_sine_cosine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic        [fpsc_pkg::ANGLE_W-1:0] req_angle,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed      [fpsc_pkg::OUT_W-1:0]   rsp_sine,
   output logic signed      [fpsc_pkg::OUT_W-1:0]   rsp_cosine
);

   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   logic        [fpsc_pkg::ANGLE_W-1:0]  angle_ff;
   logic        [fpsc_pkg::ANGLE_W-1:0]  angle_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic signed [fpsc_pkg::OUT_W-1:0]    sine_ff;
   logic signed [fpsc_pkg::OUT_W-1:0]    sine_in;
   logic signed [fpsc_pkg::OUT_W-1:0]    cosine_ff;
   logic signed [fpsc_pkg::OUT_W-1:0]    cosine_in;
   logic                                 out_load;
   logic        [16:0]                   adv;
   logic        [16:0]                   adv_wrap;
   logic        [fpsc_pkg::ANGLE_W-1:0]  cos_angle;
   logic signed [fpsc_pkg::OUT_W-1:0]    sine_calc;
   logic signed [fpsc_pkg::OUT_W-1:0]    cosine_calc;

   // handshake: result register loads when empty or being taken
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_load;

   // cosine angle: advance a quarter turn, wrap once past a full turn
   assign adv       = {1'b0, angle_ff} + fpsc_pkg::QUARTER_TURN;
   assign adv_wrap  = (adv > fpsc_pkg::FULL_TURN) ? adv - fpsc_pkg::FULL_TURN : adv;
   assign cos_angle = adv_wrap[15:0];

   fpsc_eval u_sine (
      .angle (angle_ff),
      .sine  (sine_calc)
   );

   fpsc_eval u_cosine (
      .angle (cos_angle),
      .sine  (cosine_calc)
   );

   // next-state for both stages
   always_comb begin
      in_valid_in  = in_valid_ff;
      angle_in     = angle_ff;
      rsp_valid_in = rsp_valid_ff;
      sine_in      = sine_ff;
      cosine_in    = cosine_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         angle_in    = req_angle;
      end
      if (out_load) begin
         rsp_valid_in = in_valid_ff;
         sine_in      = sine_calc;
         cosine_in    = cosine_calc;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      angle_ff  <= angle_in;
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sine   = sine_ff;
   assign rsp_cosine = cosine_ff;

endmodule

`default_nettype wire

@@ rtl/fpsc_checker.sv @@
// Port-level checks for the sine/cosine block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_point_sine_cosine_defines.svh"

module fpsc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic        [fpsc_pkg::ANGLE_W-1:0] req_angle,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [fpsc_pkg::OUT_W-1:0]   rsp_sine,
   input wire logic signed [fpsc_pkg::OUT_W-1:0]   rsp_cosine
);

   logic req_take;

   assign req_take = req_valid && !req_stall && (req_angle == req_angle);

   // no result is pending right after reset
   `FPSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // a stalled result holds its values
   `FPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sine) && $stable(rsp_cosine))

   // interpolation never reaches the most negative code
   `FPSC_ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid, rsp_sine != -16'sd32768 && rsp_cosine != -16'sd32768)

   // an accepted request reaches rsp_valid through the input and result registers when the output is not stalled
   `FPSC_ASSERT_NEXT(a_latency, clock, reset, req_take && !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind fixed_point_sine_cosine fpsc_checker u_fpsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_angle  (req_angle),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_sine   (rsp_sine),
   .rsp_cosine (rsp_cosine)
);

`default_nettype wire
